@@ rtl/gpf_pkg.sv @@
// gpf_pkg: widths, field types and pipeline stage records for gravity_pair_force.
// No dependencies; imported by the top level.
package gpf_pkg;

  localparam int unsigned POS_W   = 24;  // signed Q16.8 position
  localparam int unsigned MASS_W  = 16;
  localparam int unsigned G_W     = 24;  // unsigned Q8.16
  localparam int unsigned FORCE_W = 32;  // signed Q16.16

  localparam int unsigned AD_W    = 24;  // |delta|
  localparam int unsigned MM_W    = 32;  // m1*m2
  localparam int unsigned P_W     = 56;  // G*m1*m2
  localparam int unsigned D2_W    = 49;  // dx^2+dy^2
  localparam int unsigned DQ_W    = 31;  // distance, Q.14
  localparam int unsigned SREM_W  = 33;  // square root remainder
  localparam int unsigned MQ_W    = 56;  // magnitude quotient bits
  localparam int unsigned PH_W    = 28;  // magnitude split for partial products
  localparam int unsigned PP_W    = PH_W + AD_W;
  localparam int unsigned A_W     = MQ_W + AD_W;  // magnitude * |delta|
  localparam int unsigned CQ_W    = 32;  // component quotient bits

  localparam logic [G_W-1:0]     G_RESET  = 24'd65536;  // 1.0
  localparam logic [D2_W-1:0]    D2_ONE   = 49'd65536;  // 1.0 in Q.16
  localparam logic [FORCE_W-1:0] F_POSMAX = 32'h7fff_ffff;
  localparam logic [FORCE_W-1:0] F_NEGMIN = 32'h8000_0000;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic [MASS_W-1:0]         mass_t;
  typedef logic [G_W-1:0]            gconst_t;
  typedef logic signed [FORCE_W-1:0] force_t;

  // Magnitude divide and square root stages
  typedef struct packed {
    logic              zero;
    logic              sx;
    logic              sy;
    logic [AD_W-1:0]   adx;
    logic [AD_W-1:0]   ady;
    logic [P_W-1:0]    p;
    logic [D2_W-1:0]   d2;
    logic [D2_W-1:0]   d2c;
    logic [D2_W-1:0]   mrem;
    logic [MQ_W-1:0]   mq;
    logic [SREM_W-1:0] srem;
    logic [DQ_W-1:0]   sroot;
  } mdiv_t;

  // Component divide stages, x and y side by side
  typedef struct packed {
    logic            zero;
    logic            sx;
    logic            sy;
    logic [DQ_W-1:0] dq;
    logic            xovf;
    logic [DQ_W-1:0] xrem;
    logic [CQ_W-1:0] xq;
    logic [CQ_W-1:0] xlo;
    logic            yovf;
    logic [DQ_W-1:0] yrem;
    logic [CQ_W-1:0] yq;
    logic [CQ_W-1:0] ylo;
  } cdiv_t;

endpackage

@@ rtl/gravity_pair_force.sv @@
// gravity_pair_force: pipelined pair force, from input transaction to result.
// Throughput one pair per cycle; the 56-step magnitude divider and the 32-step
// component dividers are unrolled one quotient bit per pipeline stage.
// A stall on the output freezes the whole pipeline.
// Reset (async, active low) clears all valid bits and sets G to 1.0.
// Depends on gpf_pkg.
module gravity_pair_force (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  gpf_pkg::gconst_t cfg_grav_constant_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gpf_pkg::pos_t   first_x_i,
  input  gpf_pkg::pos_t   first_y_i,
  input  gpf_pkg::mass_t  first_mass_i,
  input  gpf_pkg::pos_t   second_x_i,
  input  gpf_pkg::pos_t   second_y_i,
  input  gpf_pkg::mass_t  second_mass_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gpf_pkg::force_t force_x_o,
  output gpf_pkg::force_t force_y_o,
  output logic            saturated_o
);
  import gpf_pkg::*;

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration ----------------
  gconst_t gconst_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gconst_q <= G_RESET;
    end else if (cfg_valid_i) begin
      gconst_q <= cfg_grav_constant_i;
    end
  end

  // ---------------- stage 1: deltas, m1*m2 ----------------
  logic [POS_W:0]  dx_w, dy_w, adx_w, ady_w;
  logic            s1_v_q;
  logic            s1_sx_q, s1_sy_q;
  logic [AD_W-1:0] s1_adx_q, s1_ady_q;
  logic [MM_W-1:0] s1_mm_q;

  assign dx_w  = {second_x_i[POS_W-1], second_x_i} - {first_x_i[POS_W-1], first_x_i};
  assign dy_w  = {second_y_i[POS_W-1], second_y_i} - {first_y_i[POS_W-1], first_y_i};
  assign adx_w = dx_w[POS_W] ? ((POS_W+1)'(0) - dx_w) : dx_w;
  assign ady_w = dy_w[POS_W] ? ((POS_W+1)'(0) - dy_w) : dy_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sx_q  <= dx_w[POS_W];
      s1_sy_q  <= dy_w[POS_W];
      s1_adx_q <= adx_w[AD_W-1:0];
      s1_ady_q <= ady_w[AD_W-1:0];
      s1_mm_q  <= first_mass_i * second_mass_i;
    end
  end

  // ---------------- stage 2: squares, G*m1*m2 ----------------
  logic              s2_v_q;
  logic              s2_sx_q, s2_sy_q;
  logic [AD_W-1:0]   s2_adx_q, s2_ady_q;
  logic [2*AD_W-1:0] s2_sqx_q, s2_sqy_q;
  logic [P_W-1:0]    s2_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_adx_q <= s1_adx_q;
      s2_ady_q <= s1_ady_q;
      s2_sqx_q <= s1_adx_q * s1_adx_q;
      s2_sqy_q <= s1_ady_q * s1_ady_q;
      s2_p_q   <= gconst_q * s1_mm_q;
    end
  end

  // ---------------- stage 3: D2, clamp, divider seed ----------------
  logic  [MQ_W:0] mv_q;
  mdiv_t          md_q [MQ_W+1];
  logic [D2_W-1:0] d2_w;

  assign d2_w = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else if (en) begin
      mv_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0].zero  <= (d2_w == '0);
      md_q[0].sx    <= s2_sx_q;
      md_q[0].sy    <= s2_sy_q;
      md_q[0].adx   <= s2_adx_q;
      md_q[0].ady   <= s2_ady_q;
      md_q[0].p     <= s2_p_q;
      md_q[0].d2    <= d2_w;
      md_q[0].d2c   <= (d2_w < D2_ONE) ? D2_ONE : d2_w;
      // top 16 bits of P<<16 lie below the divisor (>= 2^16)
      md_q[0].mrem  <= D2_W'(s2_p_q[P_W-1:P_W-16]);
      md_q[0].mq    <= '0;
      md_q[0].srem  <= '0;
      md_q[0].sroot <= '0;
    end
  end

  // ---------------- magnitude divide, one bit per stage; sqrt alongside ----------
  for (genvar j = 0; j < MQ_W; j++) begin : g_mdiv
    mdiv_t          nxt;
    logic           nbit;
    logic [D2_W:0]  mtmp;
    logic [61:0]    sv;
    logic [SREM_W+1:0] stmp;
    logic [SREM_W+1:0] strial;

    always_comb begin
      nxt = md_q[j];
      // next numerator bit of P<<16
      if (MQ_W - 1 - j >= 16) begin
        nbit = md_q[j].p[(MQ_W - 1 - j >= 16) ? (MQ_W - 17 - j) : 0];
      end else begin
        nbit = 1'b0;
      end
      mtmp = {md_q[j].mrem, nbit};
      if (mtmp >= {1'b0, md_q[j].d2c}) begin
        nxt.mrem = D2_W'(mtmp - {1'b0, md_q[j].d2c});
        nxt.mq   = {md_q[j].mq[MQ_W-2:0], 1'b1};
      end else begin
        nxt.mrem = mtmp[D2_W-1:0];
        nxt.mq   = {md_q[j].mq[MQ_W-2:0], 1'b0};
      end
      // digit-pair square root of D2<<12
      sv     = {1'b0, md_q[j].d2, 12'b0};
      stmp   = '0;
      strial = '0;
      if (j < DQ_W) begin
        stmp   = {md_q[j].srem, sv[(j < DQ_W) ? (61 - 2*j) : 1 -: 2]};
        strial = {2'b00, md_q[j].sroot, 2'b01};
        if (stmp >= strial) begin
          nxt.srem  = SREM_W'(stmp - strial);
          nxt.sroot = {md_q[j].sroot[DQ_W-2:0], 1'b1};
        end else begin
          nxt.srem  = stmp[SREM_W-1:0];
          nxt.sroot = {md_q[j].sroot[DQ_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[j+1] <= 1'b0;
      end else if (en) begin
        mv_q[j+1] <= mv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        md_q[j+1] <= nxt;
      end
    end
  end

  // ---------------- partial products magnitude * |delta| ----------------
  mdiv_t           mfin;
  logic            pp_v_q;
  logic            pp_zero_q, pp_sx_q, pp_sy_q;
  logic [DQ_W-1:0] pp_dq_q;
  logic [PP_W-1:0] ppxl_q, ppxh_q, ppyl_q, ppyh_q;

  assign mfin = md_q[MQ_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
    end else if (en) begin
      pp_v_q <= mv_q[MQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_zero_q <= mfin.zero;
      pp_sx_q   <= mfin.sx;
      pp_sy_q   <= mfin.sy;
      pp_dq_q   <= mfin.sroot;
      ppxl_q    <= mfin.mq[PH_W-1:0] * mfin.adx;
      ppxh_q    <= mfin.mq[MQ_W-1:PH_W] * mfin.adx;
      ppyl_q    <= mfin.mq[PH_W-1:0] * mfin.ady;
      ppyh_q    <= mfin.mq[MQ_W-1:PH_W] * mfin.ady;
    end
  end

  // ---------------- sum, overflow check, component divider seed ----------------
  logic [CQ_W:0] cv_q;
  cdiv_t         cd_q [CQ_W+1];
  logic [A_W-1:0]    ax_w, ay_w;
  logic [A_W-27:0]   xtop_w, ytop_w;

  assign ax_w   = {{(A_W-PP_W){1'b0}}, ppxl_q} + {ppxh_q, {PH_W{1'b0}}};
  assign ay_w   = {{(A_W-PP_W){1'b0}}, ppyl_q} + {ppyh_q, {PH_W{1'b0}}};
  // numerator is A<<6; its bits above 32 decide overflow of a 32-bit quotient
  assign xtop_w = ax_w[A_W-1:26];
  assign ytop_w = ay_w[A_W-1:26];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= pp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0].zero <= pp_zero_q;
      cd_q[0].sx   <= pp_sx_q;
      cd_q[0].sy   <= pp_sy_q;
      cd_q[0].dq   <= pp_dq_q;
      cd_q[0].xovf <= (xtop_w >= (A_W-26)'(pp_dq_q));
      cd_q[0].xrem <= xtop_w[DQ_W-1:0];
      cd_q[0].xq   <= '0;
      cd_q[0].xlo  <= {ax_w[25:0], 6'b0};
      cd_q[0].yovf <= (ytop_w >= (A_W-26)'(pp_dq_q));
      cd_q[0].yrem <= ytop_w[DQ_W-1:0];
      cd_q[0].yq   <= '0;
      cd_q[0].ylo  <= {ay_w[25:0], 6'b0};
    end
  end

  // ---------------- component divide, one bit per stage ----------------
  for (genvar j = 0; j < CQ_W; j++) begin : g_cdiv
    cdiv_t         nxt;
    logic [DQ_W:0] xtmp, ytmp;

    always_comb begin
      nxt  = cd_q[j];
      xtmp = {cd_q[j].xrem, cd_q[j].xlo[CQ_W-1]};
      ytmp = {cd_q[j].yrem, cd_q[j].ylo[CQ_W-1]};
      nxt.xlo = {cd_q[j].xlo[CQ_W-2:0], 1'b0};
      nxt.ylo = {cd_q[j].ylo[CQ_W-2:0], 1'b0};
      if (xtmp >= {1'b0, cd_q[j].dq}) begin
        nxt.xrem = DQ_W'(xtmp - {1'b0, cd_q[j].dq});
        nxt.xq   = {cd_q[j].xq[CQ_W-2:0], 1'b1};
      end else begin
        nxt.xrem = xtmp[DQ_W-1:0];
        nxt.xq   = {cd_q[j].xq[CQ_W-2:0], 1'b0};
      end
      if (ytmp >= {1'b0, cd_q[j].dq}) begin
        nxt.yrem = DQ_W'(ytmp - {1'b0, cd_q[j].dq});
        nxt.yq   = {cd_q[j].yq[CQ_W-2:0], 1'b1};
      end else begin
        nxt.yrem = ytmp[DQ_W-1:0];
        nxt.yq   = {cd_q[j].yq[CQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[j+1] <= 1'b0;
      end else if (en) begin
        cv_q[j+1] <= cv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cd_q[j+1] <= nxt;
      end
    end
  end

  // ---------------- sign, saturation, output register ----------------
  cdiv_t cfin;
  logic [FORCE_W-1:0] fx_d, fy_d;
  logic               xsat_w, ysat_w;
  logic [FORCE_W-1:0] fx_q, fy_q;
  logic               sat_q;

  assign cfin = cd_q[CQ_W];

  always_comb begin
    if (cfin.sx) begin
      xsat_w = cfin.xovf || (cfin.xq > F_NEGMIN);
      fx_d   = xsat_w ? F_NEGMIN : (FORCE_W'(0) - cfin.xq);
    end else begin
      xsat_w = cfin.xovf || cfin.xq[CQ_W-1];
      fx_d   = xsat_w ? F_POSMAX : cfin.xq;
    end
    if (cfin.sy) begin
      ysat_w = cfin.yovf || (cfin.yq > F_NEGMIN);
      fy_d   = ysat_w ? F_NEGMIN : (FORCE_W'(0) - cfin.yq);
    end else begin
      ysat_w = cfin.yovf || cfin.yq[CQ_W-1];
      fy_d   = ysat_w ? F_POSMAX : cfin.yq;
    end
    // coincident bodies
    if (cfin.zero) begin
      xsat_w = 1'b0;
      ysat_w = 1'b0;
      fx_d   = '0;
      fy_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cv_q[CQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      sat_q <= xsat_w || ysat_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign saturated_o = sat_q;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for gravity_pair_force: directed and random body pairs,
// predicted force compared against every result. Depends on gpf_pkg and the RTL.
module testbench;
  import gpf_pkg::*;

  localparam int LAT_WAIT  = 120;
  localparam int CYC_LIMIT = 300000;

  typedef struct {
    pos_t  fx, fy;
    mass_t fm;
    pos_t  sx, sy;
    mass_t sm;
  } pair_t;

  typedef struct {
    force_t fx, fy;
    logic   sat;
  } force_res_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  gconst_t cfg_g = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  pos_t    first_x = '0, first_y = '0, second_x = '0, second_y = '0;
  mass_t   first_mass = '0, second_mass = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  force_t  force_x, force_y;
  logic    saturated;

  gconst_t    g_model = G_RESET;
  force_res_t pending_forces[$];
  int         err_count = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  gravity_pair_force dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_grav_constant_i(cfg_g),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_x_i(first_x), .first_y_i(first_y), .first_mass_i(first_mass),
    .second_x_i(second_x), .second_y_i(second_y), .second_mass_i(second_mass),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .force_x_o(force_x), .force_y_o(force_y), .saturated_o(saturated)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // One axis: |mag * delta| / distance, truncated, then signed and clipped
  function automatic force_t axis_force(logic [127:0] mag, longint delta,
                                        logic [63:0] droot, inout logic sat);
    logic [127:0] ad, q;
    ad = (delta < 0) ? 128'(-delta) : 128'(delta);
    q = (mag * (ad << 6)) / droot;
    if (delta < 0) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return F_NEGMIN;
      end
      return force_t'(-q[31:0]);
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1'b1;
      return F_POSMAX;
    end
    return force_t'(q[31:0]);
  endfunction

  function automatic force_res_t pair_force(pair_t p, gconst_t g);
    longint       dx, dy;
    logic [63:0]  adx, ady, d2, droot, d2c;
    logic [127:0] prod, mag;
    force_res_t   r;
    logic         sat;
    dx = longint'(p.sx) - longint'(p.fx);
    dy = longint'(p.sy) - longint'(p.fy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    d2 = adx * adx + ady * ady;
    sat = 1'b0;
    if (d2 == 0) begin
      r.fx = '0; r.fy = '0; r.sat = 1'b0;
      return r;
    end
    droot = int_sqrt(d2 << 12);
    prod = 128'(g) * 128'(p.fm) * 128'(p.sm);
    d2c = (d2 < 64'd65536) ? 64'd65536 : d2;
    mag = (prod << 16) / d2c;
    r.fx = axis_force(mag, dx, droot, sat);
    r.fy = axis_force(mag, dy, droot, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    force_res_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (out_valid && !out_stall) begin
      if (pending_forces.size() == 0) begin
        report_mismatch("result with no pair outstanding");
      end else begin
        want = pending_forces.pop_front();
        if (force_x !== want.fx)
          report_mismatch($sformatf("force_x %0d, expected %0d", force_x, want.fx));
        if (force_y !== want.fy)
          report_mismatch($sformatf("force_y %0d, expected %0d", force_y, want.fy));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated %0b, expected %0b", saturated, want.sat));
      end
    end
  end

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_x     <= p.fx;
    first_y     <= p.fy;
    first_mass  <= p.fm;
    second_x    <= p.sx;
    second_y    <= p.sy;
    second_mass <= p.sm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_forces.insert(pending_forces.size(), pair_force(p, g_model));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_grav(gconst_t v);
    drain();
    cfg_valid <= 1'b1;
    cfg_g     <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    g_model = v;
    @(posedge clk);
  endtask

  function automatic pair_t mk(int fx, int fy, int fm, int sx, int sy, int sm);
    pair_t p;
    p.fx = pos_t'(fx); p.fy = pos_t'(fy); p.fm = mass_t'(fm);
    p.sx = pos_t'(sx); p.sy = pos_t'(sy); p.sm = mass_t'(sm);
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    span;
    p.fx = pos_t'($urandom); p.fy = pos_t'($urandom);
    case ($urandom_range(3))
      0: span = 300;        // near the unit clamp, partly inside it
      1: span = 4000;
      2: span = 1 << 20;
      default: span = 0;    // fully random second body
    endcase
    if (span == 0) begin
      p.sx = pos_t'($urandom); p.sy = pos_t'($urandom);
    end else begin
      p.sx = p.fx + pos_t'($urandom_range(2 * span) - span);
      p.sy = p.fy + pos_t'($urandom_range(2 * span) - span);
    end
    p.fm = ($urandom_range(9) == 0) ? mass_t'($urandom_range(1) * 16'hffff)
                                    : mass_t'($urandom);
    p.sm = ($urandom_range(15) == 0) ? mass_t'($urandom_range(3)) : mass_t'($urandom);
    if ($urandom_range(30) == 0) begin
      p.sx = p.fx; p.sy = p.fy;
    end
    return p;
  endfunction

  task automatic test_directed;
    send_pair(mk(0, 0, 100, 0, 0, 100));                    // coincident bodies
    send_pair(mk(-8388608, 8388607, 65535, -8388608, 8388607, 65535));
    send_pair(mk(0, 0, 65535, 1, 0, 65535));                // tiny distance
    send_pair(mk(0, 0, 65535, 0, -1, 65535));
    send_pair(mk(0, 0, 10, 128, 128, 10));                  // below one, diagonal
    send_pair(mk(0, 0, 3, 256, 0, 7));                      // exactly one
    send_pair(mk(0, 0, 0, 512, 512, 65535));                // zero mass
    send_pair(mk(0, 0, 65535, 512, 512, 0));
    send_pair(mk(-8388608, -8388608, 65535, 8388607, 8388607, 65535));
    send_pair(mk(8388607, 8388607, 65535, -8388608, -8388608, 65535));
    send_pair(mk(8388607, -8388608, 1, -8388608, 8388607, 1));
    send_pair(mk(0, 0, 1, 8388607, 0, 1));
    send_pair(mk(0, 0, 65535, -200, 100, 65535));
    send_pair(mk(1000, -1000, 500, -3000, 7000, 900));
    write_grav('0);                                         // zero G
    send_pair(mk(0, 0, 65535, 5, 9, 65535));
    send_pair(mk(0, 0, 65535, -700, 300, 65535));
    write_grav(24'hff_ffff);                                // largest G
    send_pair(mk(0, 0, 65535, 1, 1, 65535));
    send_pair(mk(0, 0, 1, 8388607, -8388608, 1));
    send_pair(mk(0, 0, 0, 3, 3, 0));
    send_pair(mk(0, 0, 2, -50000, 0, 2));
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_pair(random_pair());
  endtask

  task automatic test_random_phases;
    write_grav(G_RESET);
    run_random(250, 0, 0);
    write_grav(gconst_t'($urandom));
    run_random(250, 46, 0);
    write_grav(gconst_t'($urandom_range(255)));
    run_random(250, 0, 46);
    write_grav(24'hff_ffff);
    run_random(250, 14, 14);
    write_grav('0);
    run_random(100, 14, 14);
    write_grav(gconst_t'($urandom));
    run_random(300, 14, 14);
    write_grav(G_RESET);
    run_random(400, $urandom_range(1) * 46, $urandom_range(1) * 46);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    drain();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
